### rtl/bss_pkg.sv
// ----------------------------------------------------------------------------
// bss_pkg
// shared widths, op codes, multiplier step codes and controller/datapath
// command and status types for the bezier setpoint smoother
// ----------------------------------------------------------------------------
package bss_pkg;

   localparam int DATA_W             = 32;
   localparam int CFG_W              = 16;
   localparam int OP_W               = 2;
   localparam int TICK_WIDTH_DEFAULT = 16;

   localparam logic [CFG_W-1:0] CONVERGE_RESET = 16'd250;

   typedef logic [OP_W-1:0] op_type;

   localparam op_type OP_TICK = 2'd0;
   localparam op_type OP_SET  = 2'd1;
   localparam op_type OP_SNAP = 2'd2;

   // shared multiplier step codes
   typedef logic [3:0] mul_op_type;

   localparam mul_op_type MUL_NONE  = 4'd0;
   localparam mul_op_type MUL_THIRD = 4'd1;
   localparam mul_op_type MUL_UU    = 4'd2;
   localparam mul_op_type MUL_UT    = 4'd3;
   localparam mul_op_type MUL_UUU   = 4'd4;
   localparam mul_op_type MUL_UUT   = 4'd5;
   localparam mul_op_type MUL_B0P0  = 4'd6;
   localparam mul_op_type MUL_B1P1  = 4'd7;
   localparam mul_op_type MUL_B3P3  = 4'd8;
   localparam mul_op_type MUL_D0    = 4'd9;
   localparam mul_op_type MUL_D1    = 4'd10;

   localparam int MUL_STEPS = 10;

   // issue order puts every step after the registered results of the steps it reads
   function automatic mul_op_type mul_seq(input logic [3:0] idx);
      mul_op_type code;
      case (idx)
         4'd0:    code = MUL_THIRD;
         4'd1:    code = MUL_UU;
         4'd2:    code = MUL_UT;
         4'd3:    code = MUL_UUU;
         4'd4:    code = MUL_UUT;
         4'd5:    code = MUL_B0P0;
         4'd6:    code = MUL_B1P1;
         4'd7:    code = MUL_B3P3;
         4'd8:    code = MUL_D0;
         4'd9:    code = MUL_D1;
         default: code = MUL_NONE;
      endcase
      return code;
   endfunction

   typedef struct packed {
      logic       item_load;
      logic       update;
      logic       div_init;
      logic       div_step;
      mul_op_type mul_op;
      logic       rsp_load;
   } bss_cmd_type;

   typedef struct packed {
      logic set_op;
      logic curve_ok;
   } bss_status_type;

endpackage

### rtl/bss_if.sv
// ----------------------------------------------------------------------------
// bss_if
// valid/ready channels for the smoother: request items and result items
// ----------------------------------------------------------------------------
interface bss_req_if import bss_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic [OP_W-1:0]          op;
   logic signed [DATA_W-1:0] target_value;

   modport source (output valid, output op, output target_value, input ready);
   modport sink   (input valid, input op, input target_value, output ready);
endinterface

interface bss_rsp_if import bss_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic signed [DATA_W-1:0] current_value;
   logic signed [DATA_W-1:0] current_slope;
   logic                     value_valid;

   modport source (output valid, output current_value, output current_slope,
                   output value_valid, input ready);
   modport sink   (input valid, input current_value, input current_slope,
                   input value_valid, output ready);
endinterface

### rtl/bss_ctrl.sv
// ----------------------------------------------------------------------------
// bss_ctrl
// sequencer: accepts an item, runs the divider and multiplier steps for the
// curve before the state update (new target on a live curve) and after it
// (live curve), and loads the result register
module bss_ctrl import bss_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   output logic           req_ready,
   output logic           rsp_valid,
   input  logic           rsp_ready,
   output bss_cmd_type    cmd,
   input  bss_status_type status
);

   localparam logic [3:0] ST_IDLE     = 4'd0;
   localparam logic [3:0] ST_START    = 4'd1;
   localparam logic [3:0] ST_DIV_INIT = 4'd2;
   localparam logic [3:0] ST_DIV      = 4'd3;
   localparam logic [3:0] ST_MUL      = 4'd4;
   localparam logic [3:0] ST_FLUSH    = 4'd5;
   localparam logic [3:0] ST_UPDATE   = 4'd6;
   localparam logic [3:0] ST_CHECK    = 4'd7;
   localparam logic [3:0] ST_OUTPUT   = 4'd8;

   localparam int DIV_STEPS = CFG_W + 1;

   logic [3:0] state_ff, state_in;
   logic [4:0] step_cnt_ff, step_cnt_in;
   logic       pre_ff, pre_in;
   logic       rsp_valid_ff, rsp_valid_in;

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      step_cnt_in  = step_cnt_ff;
      pre_in       = pre_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cmd          = '0;
      cmd.mul_op   = MUL_NONE;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.item_load = 1'b1;
               state_in      = ST_START;
            end
         end
         ST_START: begin
            // a new target latches the slope of the running curve first
            if (status.set_op && status.curve_ok) begin
               pre_in   = 1'b1;
               state_in = ST_DIV_INIT;
            end else begin
               state_in = ST_UPDATE;
            end
         end
         ST_DIV_INIT: begin
            cmd.div_init = 1'b1;
            step_cnt_in  = '0;
            state_in     = ST_DIV;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (step_cnt_ff == 5'(DIV_STEPS - 1)) begin
               step_cnt_in = '0;
               state_in    = ST_MUL;
            end else begin
               step_cnt_in = step_cnt_ff + 5'd1;
            end
         end
         ST_MUL: begin
            cmd.mul_op = mul_seq(step_cnt_ff[3:0]);
            if (step_cnt_ff == 5'(MUL_STEPS - 1)) begin
               state_in = ST_FLUSH;
            end else begin
               step_cnt_in = step_cnt_ff + 5'd1;
            end
         end
         ST_FLUSH: begin
            if (pre_ff) begin
               pre_in   = 1'b0;
               state_in = ST_UPDATE;
            end else begin
               state_in = ST_OUTPUT;
            end
         end
         ST_UPDATE: begin
            cmd.update = 1'b1;
            state_in   = ST_CHECK;
         end
         ST_CHECK: begin
            state_in = status.curve_ok ? ST_DIV_INIT : ST_OUTPUT;
         end
         ST_OUTPUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.rsp_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_cnt_ff  <= '0;
         pre_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_cnt_ff  <= step_cnt_in;
         pre_ff       <= pre_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

### rtl/bss_dpath.sv
// ----------------------------------------------------------------------------
// bss_dpath
// smoother state, restoring divider for t, one shared multiplier with
// registered product, weight and accumulator registers, result register
// ----------------------------------------------------------------------------
module bss_dpath import bss_pkg::*; #(
   parameter int TICK_WIDTH = TICK_WIDTH_DEFAULT
) (
   input  logic                     clock,
   input  logic                     reset,
   input  bss_cmd_type              cmd,
   output bss_status_type           status,
   input  logic                     csr_wr_en,
   input  logic [CFG_W-1:0]         csr_wr_data,
   input  logic [OP_W-1:0]          req_op,
   input  logic signed [DATA_W-1:0] req_target_value,
   output logic signed [DATA_W-1:0] rsp_current_value,
   output logic signed [DATA_W-1:0] rsp_current_slope,
   output logic                     rsp_value_valid
);

   localparam int EXT_W  = (TICK_WIDTH > CFG_W) ? TICK_WIDTH : CFG_W;
   localparam int Q_W    = CFG_W + 1;
   localparam int MA_W   = 35;
   localparam int MB_W   = 34;
   localparam int PROD_W = MA_W + MB_W;
   localparam int FRAC_W = 16;

   localparam logic [DATA_W-1:0]        RECIP3    = 32'hAAAA_AAAB;
   localparam logic [Q_W-1:0]           ONE_Q     = 17'h1_0000;
   localparam logic signed [Q_W:0]      ONE_W     = 18'sh1_0000;
   localparam logic [52:0]              HALF_P32  = 53'h8000_0000;
   localparam logic signed [PROD_W-1:0] ROUND_C   = 69'sd32768;
   localparam logic signed [DATA_W-1:0] SAT_MAX   = 32'sh7FFF_FFFF;
   localparam logic signed [DATA_W-1:0] SAT_MIN   = 32'sh8000_0000;

   function automatic logic signed [DATA_W-1:0] round_sat(
      input logic signed [PROD_W-1:0] x
   );
      logic signed [PROD_W-1:0] r;
      logic signed [DATA_W-1:0] res;
      r = x + ROUND_C;
      r = r >>> FRAC_W;
      if (r[PROD_W-1:DATA_W-1] == '0 || r[PROD_W-1:DATA_W-1] == '1) begin
         res = r[DATA_W-1:0];
      end else if (r[PROD_W-1]) begin
         res = SAT_MIN;
      end else begin
         res = SAT_MAX;
      end
      return res;
   endfunction

   // configuration and item
   logic [CFG_W-1:0]         conv_ff, conv_in;
   logic [OP_W-1:0]          op_ff, op_in;
   logic signed [DATA_W-1:0] tgt_ff, tgt_in;

   // smoother state
   logic signed [DATA_W-1:0] target_now_ff, target_now_in;
   logic signed [DATA_W-1:0] target_before_ff, target_before_in;
   logic                     have_target_ff, have_target_in;
   logic                     have_before_ff, have_before_in;
   logic signed [DATA_W-1:0] slope_before_ff, slope_before_in;
   logic [TICK_WIDTH-1:0]    elapsed_ff, elapsed_in;

   // divider
   logic [Q_W-1:0] rem_ff, rem_in;
   logic [Q_W-1:0] quo_ff, quo_in;

   // multiplier and curve terms
   logic signed [MA_W-1:0]   mul_a;
   logic signed [MB_W-1:0]   mul_b;
   logic signed [PROD_W-1:0] prod_ff, prod_in;
   mul_op_type               tag_ff;
   logic [33:0]              uu_ff, uu_in;
   logic [Q_W-1:0]           b0_ff, b0_in;
   logic [Q_W-1:0]           b1_ff, b1_in;
   logic signed [Q_W:0]      b3_ff, b3_in;
   logic [2:0]               d0_ff, d0_in;
   logic [2:0]               d1_ff, d1_in;
   logic signed [DATA_W-1:0] third_ff, third_in;
   logic signed [DATA_W:0]   p1_ff, p1_in;
   logic signed [DATA_W+1:0] p31_ff, p31_in;
   logic signed [PROD_W-1:0] acc_ff, acc_in;
   logic signed [DATA_W-1:0] val_ff, val_in;
   logic signed [DATA_W-1:0] slp_ff, slp_in;

   // result register
   logic signed [DATA_W-1:0] out_value_ff, out_value_in;
   logic signed [DATA_W-1:0] out_slope_ff, out_slope_in;
   logic                     out_valid_ff, out_valid_in;

   logic [CFG_W-1:0]  c_val;
   logic [EXT_W-1:0]  c_ext;
   logic [EXT_W-1:0]  el_ext;
   logic [EXT_W-1:0]  tmax_ext;
   logic [EXT_W-1:0]  lim_ext;
   logic [CFG_W-1:0]  e_val;
   logic [Q_W-1:0]    u_val;
   logic [Q_W-1:0]    div_r;
   logic              div_ge;
   logic [DATA_W-1:0] slope_mag;
   logic [DATA_W-1:0] third_mag;
   logic [35:0]       d0_sum;
   logic [35:0]       d1_sum;
   logic [51:0]       b0_sum;
   logic [52:0]       b1_sum;
   logic signed [PROD_W-1:0] acc_sum;

   assign status.set_op   = (op_ff == OP_SET);
   assign status.curve_ok = have_target_ff && have_before_ff;

   assign rsp_current_value = out_value_ff;
   assign rsp_current_slope = out_slope_ff;
   assign rsp_value_valid   = out_valid_ff;

   // tick limits
   always_comb begin
      c_val    = (conv_ff == '0) ? CFG_W'(1) : conv_ff;
      c_ext    = EXT_W'(c_val);
      el_ext   = EXT_W'(elapsed_ff);
      tmax_ext = EXT_W'({TICK_WIDTH{1'b1}});
      lim_ext  = (c_ext < tmax_ext) ? c_ext : tmax_ext;
      e_val    = (el_ext < c_ext) ? el_ext[CFG_W-1:0] : c_val;
   end

   // item, configuration and state update
   always_comb begin
      conv_in          = csr_wr_en ? csr_wr_data : conv_ff;
      op_in            = op_ff;
      tgt_in           = tgt_ff;
      target_now_in    = target_now_ff;
      target_before_in = target_before_ff;
      have_target_in   = have_target_ff;
      have_before_in   = have_before_ff;
      slope_before_in  = slope_before_ff;
      elapsed_in       = elapsed_ff;

      if (cmd.item_load) begin
         op_in  = req_op;
         tgt_in = req_target_value;
      end

      if (cmd.update) begin
         case (op_ff)
            OP_TICK: begin
               if (el_ext < lim_ext) begin
                  elapsed_in = elapsed_ff + TICK_WIDTH'(1);
               end
            end
            OP_SET: begin
               slope_before_in  = status.curve_ok ? slp_ff : '0;
               target_before_in = target_now_ff;
               have_before_in   = have_target_ff;
               target_now_in    = tgt_ff;
               have_target_in   = 1'b1;
               elapsed_in       = '0;
            end
            OP_SNAP: begin
               have_before_in  = 1'b0;
               slope_before_in = '0;
            end
            default: begin
            end
         endcase
      end
   end

   // restoring divider, one quotient bit per step
   always_comb begin
      u_val  = ONE_Q - quo_ff;
      div_ge = (rem_ff >= Q_W'(c_val));
      div_r  = div_ge ? (rem_ff - Q_W'(c_val)) : rem_ff;
      rem_in = rem_ff;
      quo_in = quo_ff;
      if (cmd.div_init) begin
         rem_in = Q_W'(e_val);
         quo_in = '0;
      end else if (cmd.div_step) begin
         rem_in = {div_r[Q_W-2:0], 1'b0};
         quo_in = {quo_ff[Q_W-2:0], div_ge};
      end
   end

   // shared multiplier operand select
   always_comb begin
      slope_mag = slope_before_ff[DATA_W-1] ? (DATA_W'(0) - slope_before_ff)
                                            : slope_before_ff;
      mul_a = '0;
      mul_b = '0;
      unique case (cmd.mul_op)
         MUL_THIRD: begin
            mul_a = MA_W'(slope_mag);
            mul_b = MB_W'(RECIP3);
         end
         MUL_UU: begin
            mul_a = MA_W'(u_val);
            mul_b = MB_W'(u_val);
         end
         MUL_UT: begin
            mul_a = MA_W'(u_val);
            mul_b = MB_W'(quo_ff);
         end
         MUL_UUU: begin
            mul_a = MA_W'(uu_ff);
            mul_b = MB_W'(u_val);
         end
         MUL_UUT: begin
            mul_a = MA_W'(uu_ff);
            mul_b = MB_W'(quo_ff);
         end
         MUL_B0P0: begin
            mul_a = MA_W'(target_before_ff);
            mul_b = MB_W'(b0_ff);
         end
         MUL_B1P1: begin
            mul_a = MA_W'(p1_ff);
            mul_b = MB_W'(b1_ff);
         end
         MUL_B3P3: begin
            mul_a = MA_W'(target_now_ff);
            mul_b = MB_W'(b3_ff);
         end
         MUL_D0: begin
            mul_a = MA_W'(third_ff);
            mul_b = MB_W'(d0_ff);
         end
         MUL_D1: begin
            mul_a = MA_W'(p31_ff);
            mul_b = MB_W'(d1_ff);
         end
         default: begin
         end
      endcase
      prod_in = mul_a * mul_b;
   end

   // capture of the registered product by its step code
   always_comb begin
      third_mag = prod_ff[64:33];
      d0_sum    = 36'({prod_ff[33:0], 1'b0}) + 36'(prod_ff[33:0]) + 36'(HALF_P32);
      d1_sum    = 36'({prod_ff[33:0], 2'b0}) + 36'({prod_ff[33:0], 1'b0})
                  + 36'(HALF_P32);
      b0_sum    = 52'(prod_ff[50:0]) + 52'(HALF_P32);
      b1_sum    = 53'({prod_ff[50:0], 1'b0}) + 53'(prod_ff[50:0]) + HALF_P32;
      acc_sum   = acc_ff + prod_ff;

      uu_in    = uu_ff;
      b0_in    = b0_ff;
      b1_in    = b1_ff;
      b3_in    = b3_ff;
      d0_in    = d0_ff;
      d1_in    = d1_ff;
      third_in = third_ff;
      p1_in    = p1_ff;
      p31_in   = p31_ff;
      acc_in   = acc_ff;
      val_in   = val_ff;
      slp_in   = slp_ff;

      unique case (tag_ff)
         MUL_THIRD: begin
            third_in = slope_before_ff[DATA_W-1] ? (DATA_W'(0) - third_mag) : third_mag;
         end
         MUL_UU: begin
            uu_in  = prod_ff[33:0];
            d0_in  = d0_sum[34:32];
            p1_in  = (DATA_W+1)'(target_before_ff) + (DATA_W+1)'(third_ff);
            p31_in = (DATA_W+2)'(target_now_ff) - (DATA_W+2)'(target_before_ff)
                     - (DATA_W+2)'(third_ff);
         end
         MUL_UT: begin
            d1_in = d1_sum[34:32];
         end
         MUL_UUU: begin
            b0_in = b0_sum[48:32];
         end
         MUL_UUT: begin
            b1_in = b1_sum[48:32];
            b3_in = ONE_W - $signed({1'b0, b0_ff}) - $signed({1'b0, b1_sum[48:32]});
         end
         MUL_B0P0: begin
            acc_in = prod_ff;
         end
         MUL_B1P1: begin
            acc_in = acc_sum;
         end
         MUL_B3P3: begin
            val_in = round_sat(acc_sum);
         end
         MUL_D0: begin
            acc_in = prod_ff;
         end
         MUL_D1: begin
            slp_in = round_sat(acc_sum);
         end
         default: begin
         end
      endcase
   end

   // result select
   always_comb begin
      out_value_in = out_value_ff;
      out_slope_in = out_slope_ff;
      out_valid_in = out_valid_ff;
      if (cmd.rsp_load) begin
         out_valid_in = have_target_ff;
         if (!have_target_ff) begin
            out_value_in = '0;
            out_slope_in = '0;
         end else if (!have_before_ff) begin
            out_value_in = target_now_ff;
            out_slope_in = '0;
         end else begin
            out_value_in = val_ff;
            out_slope_in = slp_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         conv_ff          <= CONVERGE_RESET;
         target_now_ff    <= '0;
         target_before_ff <= '0;
         have_target_ff   <= 1'b0;
         have_before_ff   <= 1'b0;
         slope_before_ff  <= '0;
         elapsed_ff       <= '0;
         tag_ff           <= MUL_NONE;
      end else begin
         conv_ff          <= conv_in;
         target_now_ff    <= target_now_in;
         target_before_ff <= target_before_in;
         have_target_ff   <= have_target_in;
         have_before_ff   <= have_before_in;
         slope_before_ff  <= slope_before_in;
         elapsed_ff       <= elapsed_in;
         tag_ff           <= cmd.mul_op;
      end
   end

   always_ff @(posedge clock) begin
      op_ff        <= op_in;
      tgt_ff       <= tgt_in;
      rem_ff       <= rem_in;
      quo_ff       <= quo_in;
      prod_ff      <= prod_in;
      uu_ff        <= uu_in;
      b0_ff        <= b0_in;
      b1_ff        <= b1_in;
      b3_ff        <= b3_in;
      d0_ff        <= d0_in;
      d1_ff        <= d1_in;
      third_ff     <= third_in;
      p1_ff        <= p1_in;
      p31_ff       <= p31_in;
      acc_ff       <= acc_in;
      val_ff       <= val_in;
      slp_ff       <= slp_in;
      out_value_ff <= out_value_in;
      out_slope_ff <= out_slope_in;
      out_valid_ff <= out_valid_in;
   end

endmodule

### rtl/bezier_setpoint_smoother.sv
// ----------------------------------------------------------------------------
// bezier_setpoint_smoother
// a curve pass is 17 divider steps for t plus 10 steps of the shared multiplier
// one item at a time; the next transfer is taken once back in idle, after the result
//   register loads, while that result may still wait for its transfer
// synchronous active-high reset: converge_ticks 250, no target, output empty
// ----------------------------------------------------------------------------
module bezier_setpoint_smoother import bss_pkg::*; #(
   parameter int TICK_WIDTH = TICK_WIDTH_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   bss_req_if.sink          req_port,
   bss_rsp_if.source        rsp_port,
   input  logic             csr_wr_en,
   input  logic [CFG_W-1:0] csr_wr_data
);

   bss_cmd_type    cmd;
   bss_status_type status;

   bss_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_port.valid),
      .req_ready (req_port.ready),
      .rsp_valid (rsp_port.valid),
      .rsp_ready (rsp_port.ready),
      .cmd       (cmd),
      .status    (status)
   );

   bss_dpath #(
      .TICK_WIDTH (TICK_WIDTH)
   ) u_dpath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .csr_wr_en         (csr_wr_en),
      .csr_wr_data       (csr_wr_data),
      .req_op            (req_port.op),
      .req_target_value  (req_port.target_value),
      .rsp_current_value (rsp_port.current_value),
      .rsp_current_slope (rsp_port.current_slope),
      .rsp_value_valid   (rsp_port.value_valid)
   );

endmodule
